### hw/rtl/lsc_pkg.sv
// Shared types and constants of the load spectrum classifier.
// No dependencies; imported by the counter bank, the top level and the checker.
package lsc_pkg;

  // Item kinds carried on tuser of the input channel
  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_READ    = 2'd1,
    KIND_RESTART = 2'd2
  } kind_e;

  // Counting modes
  localparam logic [2:0] MODE_SAMPLING   = 3'd0;
  localparam logic [2:0] MODE_ZERO_CROSS = 3'd1;
  localparam logic [2:0] MODE_PEAK_ONE   = 3'd2;
  localparam logic [2:0] MODE_PEAK_TWO   = 3'd3;
  localparam logic [2:0] MODE_LEVEL      = 3'd4;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_LOWER       = 3'd1;
  localparam logic [2:0] REG_WIDTH       = 3'd2;
  localparam logic [2:0] REG_COUNT       = 3'd3;
  localparam logic [2:0] REG_HYST        = 3'd4;
  localparam logic [2:0] REG_REF         = 3'd5;
  localparam logic [2:0] REG_RESET_AFTER = 3'd6;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFE;
  localparam logic [31:0] MARKER  = 32'hFFFF_FFFF;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOP = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_SNAP = 4'b1000
  } state_e;

  // Control of the counter bank
  typedef struct packed {
    logic bump;       // increment one class counter, saturating
    logic copy_snap;  // counters -> snapshot
    logic copy_read;  // snapshot -> readout copy
    logic clear;      // zero all three arrays
  } bank_ctrl_t;

endpackage

### hw/rtl/lsc_level_unit.sv
// Shared boundary unit: steps class boundaries by the class width and compares.
// No package dependencies; instantiated once by the top level.
module lsc_level_unit #(
  parameter int CW = 40
) (
  input  logic                 clk_i,
  input  logic                 start_i,
  input  logic                 step_i,
  input  logic signed [CW-1:0] lower_i,
  input  logic signed [CW-1:0] width_i,
  input  logic signed [CW-1:0] guard_i,
  input  logic signed [CW-1:0] sample_i,
  input  logic signed [CW-1:0] prev_i,
  input  logic                 rise_i,
  input  logic                 fall_i,
  output logic                 in_class_o,
  output logic                 cross_o
);

  logic signed [CW-1:0] lo_q, lg_q, hg_q;

  // Boundary accumulators: level, narrowed low edge, narrowed high edge
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lo_q <= lower_i;
      lg_q <= lower_i + guard_i;
      hg_q <= lower_i + width_i - guard_i;
    end else if (step_i) begin
      lo_q <= lo_q + width_i;
      lg_q <= lg_q + width_i;
      hg_q <= hg_q + width_i;
    end
  end

  assign in_class_o = (sample_i >= lg_q) && (sample_i < hg_q);
  assign cross_o    = (rise_i && (prev_i <= lo_q) && (sample_i > lo_q)) ||
                      (fall_i && (prev_i > lo_q) && (sample_i < lo_q));

endmodule

### hw/rtl/lsc_counter_bank.sv
// Class counters, snapshot copy and readout copy of the classifier.
// Depends on lsc_pkg for bank_ctrl_t and CNT_MAX.
module lsc_counter_bank #(
  parameter int NUM_CLASSES = 16,
  parameter int KW          = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsc_pkg::bank_ctrl_t ctrl_i,
  input  logic [KW-1:0]       bump_idx_i,
  input  logic [KW-1:0]       rd_idx_i,
  output logic [31:0]         rd_data_o
);
  import lsc_pkg::*;

  logic [31:0] cnt_q  [NUM_CLASSES];
  logic [31:0] snap_q [NUM_CLASSES];
  logic [31:0] rdc_q  [NUM_CLASSES];

  // Counters: saturating increment, clear on restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) cnt_q[i] <= '0;
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < NUM_CLASSES; i++) cnt_q[i] <= '0;
    end else if (ctrl_i.bump && (cnt_q[bump_idx_i] < CNT_MAX)) begin
      cnt_q[bump_idx_i] <= cnt_q[bump_idx_i] + 32'd1;
    end
  end

  // Snapshot and readout copies
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        snap_q[i] <= '0;
        rdc_q[i]  <= '0;
      end
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        snap_q[i] <= '0;
        rdc_q[i]  <= '0;
      end
    end else begin
      if (ctrl_i.copy_snap) begin
        for (int i = 0; i < NUM_CLASSES; i++) snap_q[i] <= cnt_q[i];
      end
      if (ctrl_i.copy_read) begin
        for (int i = 0; i < NUM_CLASSES; i++) rdc_q[i] <= snap_q[i];
      end
    end
  end

  assign rd_data_o = rdc_q[rd_idx_i];

endmodule

### hw/rtl/load_spectrum_classifier_top.sv
// Load spectrum classifier, top level: config port, item sequencer, history.
// Depends on lsc_pkg, lsc_level_unit and lsc_counter_bank.
//
// Use: items enter on the s_axis channel; tuser selects a sample, a read or a
// restart. Samples are counted into amplitude classes under the mode set in
// the registers. A read item returns one word on m_axis: an all-ones marker
// at the start of a snapshot, then one count per class in use.
// Results: a read item shows its word on m_axis in the cycle after acceptance;
// restart and reserved items are handled in the idle state.
// Sample path: in modes 0 to 4 a sample sweeps the classes in use in ST_LOOP,
// then passes ST_FIN and ST_SNAP; in reserved modes it goes straight to ST_SNAP.
// The boundary unit visits one class per cycle and the counter bank takes one
// increment per cycle. s_axis_tready is low meanwhile.
// Stall: a waiting result holds m_axis; the block takes a further item only while the
// sequencer is idle and the result register is free or is emptied in the same cycle.
// Reset: counters, snapshot and history clear, registers take their reset
// values, and the first read returns the marker.
module load_spectrum_classifier_top #(
  parameter int NUM_CLASSES = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // tdata: sample [SAMPLE_BITS-1:0], zero padded to bytes
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // tuser: kind [1:0]
  input  logic [1:0]                            s_axis_tuser,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: read_data [31:0]
  output logic [31:0]                           m_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [4:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import lsc_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int HW = (SB > 16) ? SB : 16;
  localparam int KW = $clog2(NUM_CLASSES);
  localparam int NW = $clog2(NUM_CLASSES + 1);
  localparam int CW = ((SB > 18) ? SB : 18) + KW + 18;

  // Configuration registers
  logic        [2:0]  cfg_mode_q;
  logic signed [15:0] cfg_lower_q;
  logic        [15:0] cfg_width_q;
  logic        [4:0]  cfg_count_q;
  logic        [14:0] cfg_hyst_q;
  logic signed [15:0] cfg_ref_q;
  logic        [31:0] cfg_rst_after_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode_q      <= MODE_SAMPLING;
      cfg_lower_q     <= '0;
      cfg_width_q     <= 16'd4096;
      cfg_count_q     <= 5'd16;
      cfg_hyst_q      <= '0;
      cfg_ref_q       <= '0;
      cfg_rst_after_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_MODE:        cfg_mode_q      <= pwdata[2:0];
        REG_LOWER:       cfg_lower_q     <= pwdata[15:0];
        REG_WIDTH:       cfg_width_q     <= pwdata[15:0];
        REG_COUNT:       cfg_count_q     <= pwdata[4:0];
        REG_HYST:        cfg_hyst_q      <= pwdata[14:0];
        REG_REF:         cfg_ref_q       <= pwdata[15:0];
        REG_RESET_AFTER: cfg_rst_after_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[4:2])
      REG_MODE:        prdata = 32'(cfg_mode_q);
      REG_LOWER:       prdata = 32'(unsigned'(cfg_lower_q));
      REG_WIDTH:       prdata = 32'(cfg_width_q);
      REG_COUNT:       prdata = 32'(cfg_count_q);
      REG_HYST:        prdata = 32'(cfg_hyst_q);
      REG_REF:         prdata = 32'(unsigned'(cfg_ref_q));
      REG_RESET_AFTER: prdata = cfg_rst_after_q;
      default:         prdata = '0;
    endcase
  end

  // Classes in use, clamped to 1..NUM_CLASSES
  logic [NW-1:0] n_cls;
  always_comb begin
    if (cfg_count_q == 5'd0) begin
      n_cls = NW'(1);
    end else if (32'(cfg_count_q) > 32'(NUM_CLASSES)) begin
      n_cls = NW'(NUM_CLASSES);
    end else begin
      n_cls = NW'(cfg_count_q);
    end
  end

  // Sequencer and history state
  state_e               state_q, state_d;
  logic signed [HW-1:0] v_q, v_d, p_q, p_d, pp_q, pp_d, hp_q, hp_d, lv_q, lv_d;
  logic [KW-1:0]        lastc_q, lastc_d, peakc_q, peakc_d, valc_q, valc_d;
  logic                 last_ok_q, last_ok_d, peak_ok_q, peak_ok_d, val_ok_q, val_ok_d;
  logic                 ra_q, ra_d, fa_q, fa_d;
  logic [31:0]          seen_q, seen_d;
  logic [NW-1:0]        phase_q, phase_d, rpos_q, rpos_d;
  logic                 frp_q, frp_d;
  logic                 found_q, found_d;
  logic [KW-1:0]        kfound_q, kfound_d, k_q, k_d;
  logic                 out_valid_q, out_valid_d;
  logic [31:0]          out_data_q, out_data_d;

  logic                 in_acc, lu_start, lu_step, lu_in_class, lu_cross;
  logic signed [HW-1:0] sample_in;
  logic signed [CW-1:0] ce_lower, ce_width, ce_guard, ce_hyst, ce_up, ce_dn;
  logic signed [CW-1:0] ce_v, ce_p, ce_pp, ce_hp, ce_vin;
  bank_ctrl_t           bank_ctrl;
  logic [KW-1:0]        bump_idx;
  logic [31:0]          rd_data;

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign sample_in     = HW'(signed'(s_axis_tdata[SB-1:0]));
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Extended operands for compares
  assign ce_lower = CW'(cfg_lower_q);
  assign ce_width = CW'(signed'({1'b0, cfg_width_q}));
  assign ce_hyst  = CW'(signed'({1'b0, cfg_hyst_q}));
  assign ce_guard = ((cfg_mode_q == MODE_SAMPLING) || (cfg_mode_q == MODE_PEAK_TWO)) ?
                    ce_hyst : '0;
  assign ce_up    = CW'(cfg_ref_q) + ce_hyst;
  assign ce_dn    = CW'(cfg_ref_q) - ce_hyst;
  assign ce_v     = CW'(v_q);
  assign ce_p     = CW'(p_q);
  assign ce_pp    = CW'(pp_q);
  assign ce_hp    = CW'(hp_q);
  assign ce_vin   = CW'(sample_in);

  lsc_level_unit #(.CW(CW)) u_level (
    .clk_i      (clk_i),
    .start_i    (lu_start),
    .step_i     (lu_step),
    .lower_i    (ce_lower),
    .width_i    (ce_width),
    .guard_i    (ce_guard),
    .sample_i   (ce_v),
    .prev_i     (ce_p),
    .rise_i     (ra_q),
    .fall_i     (fa_q),
    .in_class_o (lu_in_class),
    .cross_o    (lu_cross)
  );

  lsc_counter_bank #(.NUM_CLASSES(NUM_CLASSES), .KW(KW)) u_bank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (bank_ctrl),
    .bump_idx_i (bump_idx),
    .rd_idx_i   (rpos_q[KW-1:0]),
    .rd_data_o  (rd_data)
  );

  // Sequencer
  always_comb begin
    logic          ra, fa, endp, endn, pok, vok, restart_req;
    logic [KW-1:0] pc, vc;
    logic [NW-1:0] ph;

    state_d     = state_q;
    v_d = v_q; p_d = p_q; pp_d = pp_q; hp_d = hp_q; lv_d = lv_q;
    lastc_d = lastc_q; peakc_d = peakc_q; valc_d = valc_q;
    last_ok_d = last_ok_q; peak_ok_d = peak_ok_q; val_ok_d = val_ok_q;
    ra_d = ra_q; fa_d = fa_q;
    seen_d = seen_q; phase_d = phase_q; rpos_d = rpos_q; frp_d = frp_q;
    found_d = found_q; kfound_d = kfound_q; k_d = k_q;
    out_valid_d = out_valid_q; out_data_d = out_data_q;
    lu_start = 1'b0; lu_step = 1'b0;
    bank_ctrl = '0; bump_idx = '0;
    restart_req = 1'b0;
    ra = ra_q; fa = fa_q; endp = 1'b0; endn = 1'b0;
    pok = peak_ok_q; vok = val_ok_q; pc = peakc_q; vc = valc_q;
    ph = phase_q + NW'(1);

    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (kind_e'(s_axis_tuser))
            KIND_SAMPLE: begin
              v_d      = sample_in;
              k_d      = '0;
              found_d  = 1'b0;
              lu_start = 1'b1;
              if (cfg_mode_q == MODE_LEVEL) begin
                // Level mode arms before the level sweep
                if ((ce_p <= ce_up) && (ce_vin > ce_dn)) ra = 1'b1;
                if (ra && (ce_p > ce_up) && (ce_vin < ce_dn)) ra = 1'b0;
                if ((ce_p >= ce_up) && (ce_vin < ce_dn)) fa = 1'b1;
                if (fa && (ce_p < ce_dn) && (ce_vin > ce_up)) fa = 1'b0;
                ra_d = ra;
                fa_d = fa;
              end
              state_d = (cfg_mode_q <= MODE_LEVEL) ? ST_LOOP : ST_SNAP;
            end
            KIND_READ: begin
              out_valid_d = 1'b1;
              if (frp_q) begin
                frp_d      = 1'b0;
                out_data_d = MARKER;
              end else if (rpos_q >= n_cls) begin
                bank_ctrl.copy_read = 1'b1;
                rpos_d     = '0;
                out_data_d = MARKER;
              end else begin
                out_data_d = rd_data;
                rpos_d     = rpos_q + NW'(1);
              end
            end
            KIND_RESTART: restart_req = 1'b1;
            default: ;
          endcase
        end
      end

      // One class or level per cycle
      ST_LOOP: begin
        lu_step = 1'b1;
        if (cfg_mode_q == MODE_LEVEL) begin
          bank_ctrl.bump = lu_cross;
          bump_idx       = k_q;
        end else if (lu_in_class && !found_q) begin
          found_d  = 1'b1;
          kfound_d = k_q;
        end
        if ((NW'(k_q) + NW'(1)) >= n_cls) begin
          state_d = ST_FIN;
        end else begin
          k_d = k_q + KW'(1);
        end
      end

      // Mode specific counting and history
      ST_FIN: begin
        state_d = ST_SNAP;
        case (cfg_mode_q)
          MODE_SAMPLING: begin
            bank_ctrl.bump = found_q;
            bump_idx       = kfound_q;
          end
          MODE_ZERO_CROSS: begin
            if (found_q) begin
              if ((ce_p <= ce_dn) && (ce_v > ce_up)) ra = 1'b1;
              if (ra && (ce_p > ce_up) && (ce_v < ce_dn)) begin
                ra = 1'b0; endp = 1'b1;
              end
              if ((ce_p > ce_pp) && (ce_p > ce_v) && (ce_p > ce_hp)) begin
                hp_d = p_q; pok = last_ok_q; pc = lastc_q;
              end
              if ((ce_p >= ce_up) && (ce_v < ce_dn)) fa = 1'b1;
              if (fa && (ce_p < ce_dn) && (ce_v > ce_up)) begin
                fa = 1'b0; endn = 1'b1;
              end
              if ((ce_p < ce_pp) && (ce_p < ce_v) && (CW'(p_q) < CW'(lv_q))) begin
                lv_d = p_q; vok = last_ok_q; vc = lastc_q;
              end
              ra_d = ra; fa_d = fa;
              peak_ok_d = pok; peakc_d = pc; val_ok_d = vok; valc_d = vc;
              bank_ctrl.bump = (endp && pok) || (endn && vok);
              bump_idx       = endp ? pc : vc;
              pp_d = p_q; p_d = v_q; last_ok_d = 1'b1; lastc_d = kfound_q;
            end
          end
          MODE_PEAK_ONE: begin
            if (found_q) begin
              if ((ce_p <= ce_dn) && (ce_v > ce_up)) ra = 1'b1;
              if (ra && (ce_p > ce_up) && (ce_v < ce_dn)) ra = 1'b0;
              if ((ce_p >= ce_up) && (ce_v < ce_dn)) fa = 1'b1;
              if (fa && (ce_p < ce_dn) && (ce_v > ce_up)) fa = 1'b0;
              ra_d = ra; fa_d = fa;
              bank_ctrl.bump = last_ok_q &&
                (((ce_p > ce_pp) && (ce_p > ce_v) && ra) ||
                 ((ce_p < ce_pp) && (ce_p < ce_v) && fa));
              bump_idx = lastc_q;
              pp_d = p_q; p_d = v_q; last_ok_d = 1'b1; lastc_d = kfound_q;
            end
          end
          MODE_PEAK_TWO: begin
            if (found_q) begin
              bank_ctrl.bump = last_ok_q &&
                (((ce_p > ce_pp) && (ce_p > ce_v)) || ((ce_p < ce_pp) && (ce_p < ce_v)));
              bump_idx = lastc_q;
              pp_d = p_q; p_d = v_q; last_ok_d = 1'b1; lastc_d = kfound_q;
            end
          end
          MODE_LEVEL: p_d = v_q;
          default: ;
        endcase
      end

      // Snapshot cadence and automatic restart
      ST_SNAP: begin
        state_d = ST_IDLE;
        if (ph >= n_cls) begin
          bank_ctrl.copy_snap = 1'b1;
          phase_d = '0;
        end else begin
          phase_d = ph;
        end
        seen_d = seen_q + 32'd1;
        if ((cfg_rst_after_q != 32'd0) && (seen_d == cfg_rst_after_q)) restart_req = 1'b1;
      end

      default: state_d = ST_IDLE;
    endcase

    if (restart_req) begin
      bank_ctrl.clear = 1'b1;
      p_d = HW'(cfg_ref_q); pp_d = HW'(cfg_ref_q);
      hp_d = HW'(cfg_ref_q); lv_d = HW'(cfg_ref_q);
      last_ok_d = 1'b0; peak_ok_d = 1'b0; val_ok_d = 1'b0;
      lastc_d = '0; peakc_d = '0; valc_d = '0;
      ra_d = 1'b0; fa_d = 1'b0;
      seen_d = '0; phase_d = '0; rpos_d = '0; frp_d = 1'b1;
    end
  end

  // Control and history registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p_q         <= '0;
      pp_q        <= '0;
      hp_q        <= '0;
      lv_q        <= '0;
      lastc_q     <= '0;
      peakc_q     <= '0;
      valc_q      <= '0;
      last_ok_q   <= 1'b0;
      peak_ok_q   <= 1'b0;
      val_ok_q    <= 1'b0;
      ra_q        <= 1'b0;
      fa_q        <= 1'b0;
      seen_q      <= '0;
      phase_q     <= '0;
      rpos_q      <= '0;
      frp_q       <= 1'b1;
      found_q     <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      p_q         <= p_d;
      pp_q        <= pp_d;
      hp_q        <= hp_d;
      lv_q        <= lv_d;
      lastc_q     <= lastc_d;
      peakc_q     <= peakc_d;
      valc_q      <= valc_d;
      last_ok_q   <= last_ok_d;
      peak_ok_q   <= peak_ok_d;
      val_ok_q    <= val_ok_d;
      ra_q        <= ra_d;
      fa_q        <= fa_d;
      seen_q      <= seen_d;
      phase_q     <= phase_d;
      rpos_q      <= rpos_d;
      frp_q       <= frp_d;
      found_q     <= found_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    v_q        <= v_d;
    kfound_q   <= kfound_d;
    out_data_q <= out_data_d;
  end

endmodule

### hw/rtl/lsc_checker.sv
// Port-level checks of the load spectrum classifier, bound to the top level.
// Depends on lsc_pkg for the item kind codes.
module lsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  import lsc_pkg::*;

  // A sample keeps the sequencer busy for at least the next cycle
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_SAMPLE) |=> !s_axis_tready)
    else $error("input ready right after a sample item");

  // Every read item yields a result in the next cycle
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_READ) |=> m_axis_tvalid)
    else $error("read item without result");

  // Other items never invent a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != KIND_READ) && !m_axis_tvalid
    |=> !m_axis_tvalid)
    else $error("result without a read item");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind load_spectrum_classifier_top lsc_checker u_lsc_checker (.*);
